FILE: hw/rtl/isl_pkg.sv
// shared types and codes for the indexed shift list
`default_nettype none

package isl_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    action_t            action;
    logic [5:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [6:0]         entry_count;
  } rsp_t;

  // per-cycle command broadcast to every cell, only set for legal actions
  typedef struct packed {
    logic ins;
    logic rem;
    logic app;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/isl_cell.sv
// one list slot: holds an entry and trades it with its neighbors
`default_nettype none

module isl_cell #(
  parameter int INDEX = 0,
  parameter int XW    = 7
) (
  input  wire logic               clk,
  input  wire isl_pkg::cell_cmd_t cmd,
  input  wire logic [XW-1:0]      pos,
  input  wire logic [XW-1:0]      cnt,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] from_lower,
  input  wire logic signed [31:0] from_upper,
  output logic signed [31:0]      data,
  output logic signed [31:0]      rd
);
  import isl_pkg::*;

  localparam logic [XW-1:0] ME = XW'(INDEX);

  logic load_new;
  logic take_lower;
  logic take_upper;
  logic signed [31:0] data_next;

  always_comb begin
    load_new   = (cmd.ins && ME == pos) || (cmd.app && ME == cnt);
    take_lower = cmd.ins && ME > pos && ME <= cnt;
    take_upper = cmd.rem && ME >= pos && (ME + XW'(1)) < cnt;
    if (load_new) begin
      data_next = value;
    end else if (take_lower) begin
      data_next = from_lower;
    end else if (take_upper) begin
      data_next = from_upper;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // drives the shared read bus only when addressed
  assign rd = (ME == pos) ? data : 32'sd0;

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_shift_list.sv
// top level of the indexed shift list: control, count and a row of cells
//
//   channel | signals                        | direction | carries
//   req     | req_valid, req_ready, req      | in        | action, position, value
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | read_value, status, entry_count
//
// every action takes effect at the request transfer: the result appears in the output
// register the cycle after the transfer, and one item per cycle is sustained while
// rsp_ready is high; this rests on the cell row, where every cell compares its own index
// with the position and count and shifts or loads in the same cycle
// reset (rst, synchronous) clears the count and the output valid; the entries
// are not cleared, slots at or above the count are never read
// req_ready drops only while a result sits in the output register unaccepted
`default_nettype none

module indexed_shift_list #(
  parameter int CAPACITY = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire isl_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output isl_pkg::rsp_t      rsp
);
  import isl_pkg::*;

  // count width, and a compare width that also covers the 6-bit position
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          take;
  logic          full;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  status_t       status;
  cell_cmd_t     cmd;
  logic          rd_ok;
  logic signed [31:0] rd_bus;

  // neighbor links: slot i reads lower[i] and upper[i]
  logic signed [31:0] cell_data [CAPACITY];
  logic signed [31:0] cell_rd   [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;
  assign full      = count == CW'(CAPACITY);
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(count);

  // decode the action and its range checks; range check comes before full
  always_comb begin
    status = ST_OK;
    cmd    = '0;
    rd_ok  = 1'b0;
    unique case (req.action)
      ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.app = take;
        end
      end
      ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = take;
        end
      end
      ACT_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          cmd.rem = take;
        end
      end
      ACT_READ: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.app || cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
  end

  // the row of cells; the ends see zero from outside the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    if (i == 0) begin : g_first
      assign lower = 32'sd0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = 32'sd0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    isl_cell #(
      .INDEX (i),
      .XW    (XW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_x),
      .cnt        (cnt_x),
      .value      (req.value),
      .from_lower (lower),
      .from_upper (upper),
      .data       (cell_data[i]),
      .rd         (cell_rd[i])
    );
  end

  // read bus: only the addressed cell drives a nonzero value
  always_comb begin
    rd_bus = 32'sd0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (take) begin
      rsp.read_value  <= rd_ok ? rd_bus : 32'sd0;
      rsp.status      <= status;
      rsp.entry_count <= 7'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/isl_checker.sv
// port-level checks for the indexed shift list, bound to the top level
`default_nettype none

module isl_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire isl_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire isl_pkg::rsp_t rsp
);
  import isl_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // every request transfer yields a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("result missing after request transfer");

  // only reads return data
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.action != ACT_READ |=> rsp.read_value == 32'sd0)
    else $error("nonzero read value for a non-read action");

  // the block stalls requests only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side stalled without a pending result");

endmodule

bind indexed_shift_list isl_checker u_isl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
